FILE: src/sfg_pkg.sv
// ----------------------------------------------------------------------------
// SBUS frame generator package
// Shared types, constants and a helper function for the frame generator.
// ----------------------------------------------------------------------------
package sfg_pkg;

	// Frame layout.
	localparam int FRAME_BYTES = 25;
	localparam int DATA_FIRST  = 1;
	localparam int DATA_LAST   = 22;
	localparam int FLAG_POS    = 23;
	localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);

	// Channel store geometry.
	localparam int NUM_CH = 16;
	localparam int CH_W   = 11;
	localparam int CH_IDX_W = $clog2(NUM_CH);

	// Frame byte constants.
	localparam logic [7:0] SYNC_BYTE     = 8'h0F;
	localparam logic [7:0] FAILSAFE_FLAG = 8'h10;
	localparam logic [7:0] END_BYTE      = 8'h00;
	localparam logic [7:0] NO_FLAG       = 8'h00;

	// Serial word width: byte, parity, stop.
	localparam int WORD_W = 10;

	// Configuration reset values.
	localparam logic [7:0]  FRAME_PERIOD_RST  = 8'd9;
	localparam logic [15:0] FAILSAFE_DELAY_RST = 16'd500;

	// Commands on the input channel.
	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_LIVE_WR  = 2'd1,
		CMD_FS_WR    = 2'd2
	} command_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_FRAME_PERIOD   = 2'd0,
		CFG_FAILSAFE_DELAY = 2'd1,
		CFG_OUTPUT_ENABLE  = 2'd2,
		CFG_CUSTOM_FS      = 2'd3
	} cfg_reg_t;

	// Frame sequencer states.
	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// Channel write request into the stores.
	typedef struct packed {
		logic                live_we;
		logic                fs_we;
		logic [CH_IDX_W-1:0] idx;
		logic [CH_W-1:0]     value;
	} chan_wr_t;

	// Channel read request from the sequencer.
	typedef struct packed {
		logic                en;
		logic                copy;
		logic [CH_IDX_W-1:0] idx;
	} chan_rd_t;

	// Frame start request from the command decoder.
	typedef struct packed {
		logic start;
		logic failsafe;
		logic copy;
	} frame_req_t;

	// Byte with even parity in bit 8 and the stop bit in bit 9.
	function automatic logic [WORD_W-1:0] sfg_word(input logic [7:0] b);
		sfg_word = {1'b1, ^b, b};
	endfunction

endpackage

FILE: src/sfg_chan_store.sv
// ----------------------------------------------------------------------------
// SBUS channel stores
// Live and failsafe channel registers with one write port and one read port.
// ----------------------------------------------------------------------------
module sfg_chan_store
	import sfg_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  chan_wr_t        wr,
	input  chan_rd_t        rd,
	output logic [CH_W-1:0] rd_data
);

	logic [CH_W-1:0] live_q [NUM_CH];
	logic [CH_W-1:0] fs_q   [NUM_CH];

	// A read with copy returns the failsafe value and writes it into the live store.
	assign rd_data = rd.copy ? fs_q[rd.idx] : live_q[rd.idx];

	// Live store: written by a live request or by the failsafe copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				live_q[i] <= '0;
			end
		end else if (wr.live_we) begin
			live_q[wr.idx] <= wr.value;
		end else if (rd.en && rd.copy) begin
			live_q[rd.idx] <= fs_q[rd.idx];
		end
	end

	// Failsafe store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				fs_q[i] <= '0;
			end
		end else if (wr.fs_we) begin
			fs_q[wr.idx] <= wr.value;
		end
	end

endmodule

FILE: src/sfg_frame_seq.sv
// ----------------------------------------------------------------------------
// SBUS frame sequencer
// Walks the 25 frame bytes, packs channels LSB-first through a small bit
// buffer, and drives the registered serial word output.
// ----------------------------------------------------------------------------
module sfg_frame_seq
	import sfg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  frame_req_t        req,
	input  logic [CH_W-1:0]   rd_data,
	output chan_rd_t          rd,
	output logic              idle,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] serial_word,
	output logic              last_in_frame
);

	localparam int BUF_W = CH_W + 7;
	localparam int NB_W  = $clog2(BUF_W + 1);

	seq_state_t              state_q, state_d;
	logic [BYTE_IDX_W-1:0]   byte_q, byte_d;
	logic [CH_IDX_W-1:0]     ch_q, ch_d;
	logic [BUF_W-1:0]        buf_q, buf_d;
	logic [NB_W-1:0]         nb_q, nb_d;
	logic                    copy_q, copy_d;
	logic [7:0]              flag_q, flag_d;
	logic                    out_valid_q;
	logic [WORD_W-1:0]       word_q;
	logic                    last_q;
	logic                    slot_free;
	logic                    data_byte;
	logic                    need_load;
	logic                    emit;
	logic [7:0]              cur_byte;
	logic                    cur_last;

	assign slot_free = !out_valid_q || out_ready;
	assign data_byte = byte_q inside {[BYTE_IDX_W'(DATA_FIRST):BYTE_IDX_W'(DATA_LAST)]};
	assign need_load = (state_q == SEQ_RUN) && data_byte && (nb_q < NB_W'(8));
	assign emit      = (state_q == SEQ_RUN) && !need_load && slot_free;
	assign cur_last  = (byte_q == BYTE_IDX_W'(FRAME_BYTES - 1));

	assign rd.en   = need_load;
	assign rd.copy = copy_q;
	assign rd.idx  = ch_q;

	assign idle          = (state_q == SEQ_IDLE);
	assign out_valid     = out_valid_q;
	assign serial_word   = word_q;
	assign last_in_frame = last_q;

	// Byte selection for the current frame position.
	always_comb begin
		if (byte_q == '0) begin
			cur_byte = SYNC_BYTE;
		end else if (data_byte) begin
			cur_byte = buf_q[7:0];
		end else if (byte_q == BYTE_IDX_W'(FLAG_POS)) begin
			cur_byte = flag_q;
		end else begin
			cur_byte = END_BYTE;
		end
	end

	// Next state: start on a request, then load channels or emit bytes.
	always_comb begin
		state_d = state_q;
		byte_d  = byte_q;
		ch_d    = ch_q;
		buf_d   = buf_q;
		nb_d    = nb_q;
		copy_d  = copy_q;
		flag_d  = flag_q;
		case (state_q)
			SEQ_IDLE: begin
				if (req.start) begin
					state_d = SEQ_RUN;
					byte_d  = '0;
					ch_d    = '0;
					buf_d   = '0;
					nb_d    = '0;
					copy_d  = req.copy;
					flag_d  = req.failsafe ? FAILSAFE_FLAG : NO_FLAG;
				end
			end
			SEQ_RUN: begin
				if (need_load) begin
					buf_d = buf_q | (BUF_W'(rd_data) << nb_q[2:0]);
					nb_d  = nb_q + NB_W'(CH_W);
					ch_d  = ch_q + CH_IDX_W'(1);
				end else if (emit) begin
					if (data_byte) begin
						buf_d = buf_q >> 8;
						nb_d  = nb_q - NB_W'(8);
					end
					if (cur_last) begin
						state_d = SEQ_IDLE;
					end else begin
						byte_d = byte_q + BYTE_IDX_W'(1);
					end
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			byte_q  <= '0;
			ch_q    <= '0;
			nb_q    <= '0;
			copy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			byte_q  <= byte_d;
			ch_q    <= ch_d;
			nb_q    <= nb_d;
			copy_q  <= copy_d;
		end
	end

	// Packing buffer and flag byte.
	always_ff @(posedge clk) begin
		buf_q  <= buf_d;
		flag_q <= flag_d;
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= sfg_word(cur_byte);
			last_q <= cur_last;
		end
	end

endmodule

FILE: src/sbus_frame_generator_core.sv
// ----------------------------------------------------------------------------
// SBUS frame generator core
// Channel stores, millisecond counters and a frame sequencer that emits
// 25 serial words per frame on each eligible millisecond tick.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid/in_ready    command, channel_index, channel_value
//  out      out_valid/out_ready  serial_word, last_in_frame
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Channel writes and ticks that send no frame leave in_ready high.
// A tick that sends a frame holds in_ready low while the sequencer runs: 25 byte
// emits plus 16 channel loads through the single store read port.
// A stalled output register stretches the frame by the stall length.
// Reset clears the stores and the silence counter and sets the frame counter
// to its maximum, so the first eligible tick sends at once.
// ----------------------------------------------------------------------------
module sbus_frame_generator_core
	import sfg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [CH_IDX_W-1:0] channel_index,
	input  logic [CH_W-1:0]     channel_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [WORD_W-1:0]   serial_word,
	output logic                last_in_frame,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	logic [7:0]  frame_period_q;
	logic [15:0] failsafe_delay_q;
	logic        output_enable_q;
	logic        custom_fs_q;
	logic        seen_q;
	logic [15:0] ms_chan_q;
	logic [7:0]  ms_frame_q;
	logic [15:0] ms_chan_inc;
	logic [7:0]  ms_frame_inc;
	logic        in_fire;
	logic        is_tick;
	logic        send;
	logic        seq_idle;
	chan_wr_t    chan_wr;
	chan_rd_t    chan_rd;
	frame_req_t  frame_req;
	logic [CH_W-1:0] rd_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = seq_idle;
	assign in_fire   = in_valid && in_ready;
	assign is_tick   = in_fire && (command == CMD_TICK);

	// Saturating millisecond counters after a tick.
	assign ms_chan_inc  = (ms_chan_q == '1) ? ms_chan_q : ms_chan_q + 16'd1;
	assign ms_frame_inc = (ms_frame_q == '1) ? ms_frame_q : ms_frame_q + 8'd1;
	assign send = is_tick && seen_q && output_enable_q && (ms_frame_inc >= frame_period_q);

	// Frame start request with the failsafe decision.
	always_comb begin
		frame_req.start    = send;
		frame_req.failsafe = ms_chan_inc > failsafe_delay_q;
		frame_req.copy     = frame_req.failsafe && custom_fs_q;
	end

	// Channel write requests.
	always_comb begin
		chan_wr.live_we = in_fire && (command == CMD_LIVE_WR);
		chan_wr.fs_we   = in_fire && (command == CMD_FS_WR);
		chan_wr.idx     = channel_index;
		chan_wr.value   = channel_value;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q   <= FRAME_PERIOD_RST;
			failsafe_delay_q <= FAILSAFE_DELAY_RST;
			output_enable_q  <= 1'b1;
			custom_fs_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_PERIOD:   frame_period_q   <= cfg_data[7:0];
				CFG_FAILSAFE_DELAY: failsafe_delay_q <= cfg_data;
				CFG_OUTPUT_ENABLE:  output_enable_q  <= cfg_data[0];
				CFG_CUSTOM_FS:      custom_fs_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Command handling: counters and the channels-seen flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			ms_chan_q  <= '0;
			ms_frame_q <= '1;
		end else if (in_fire) begin
			case (command)
				CMD_TICK: begin
					ms_chan_q  <= ms_chan_inc;
					ms_frame_q <= send ? 8'd0 : ms_frame_inc;
				end
				CMD_LIVE_WR: begin
					seen_q    <= 1'b1;
					ms_chan_q <= '0;
				end
				default: ;
			endcase
		end
	end

	sfg_chan_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (chan_wr),
		.rd      (chan_rd),
		.rd_data (rd_data)
	);

	sfg_frame_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (frame_req),
		.rd_data       (rd_data),
		.rd            (chan_rd),
		.idle          (seq_idle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.serial_word   (serial_word),
		.last_in_frame (last_in_frame)
	);

`ifndef SYNTHESIS
	// The closing word of a frame is the zero byte with its stop bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_in_frame |-> serial_word == 10'h200)
		else $error("last word of frame is not the end byte");

	// Every word carries a stop bit and even parity over byte and parity bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> serial_word[9] && !(^serial_word[8:0]))
		else $error("serial word framing or parity wrong");

	// A tick that sends a frame blocks new requests on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		send |=> !in_ready)
		else $error("input accepted while a frame is being sent");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SBUS frame generator core testbench
// Drives channel writes and millisecond ticks through the request channel,
// changes the registers between phases, and compares every serial word
// against a behavioral predictor of the channel stores, counters and framing.
// A short scripted part is followed by randomized phases. Both sides of the
// core idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
	import sfg_pkg::*;

	// Command code with no meaning; the core must ignore it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic       STOP_BIT   = 1'b1;

	localparam int RESET_CYCLES    = 10;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TAIL_CYCLES     = 60;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int RAND_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 26;
	localparam int MAX_SHOWN       = 40;
	localparam int SCRIPT_ROWS     = 24;

	typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_ZERO_FRAME} chk_t;
	typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [1:0]          cmd;
		logic [CH_IDX_W-1:0] idx;
		logic [CH_W-1:0]     val;
		cfg_reg_t            reg_sel;
		logic [15:0]         data;
		chk_t                chk;
	} script_row_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} frame_word_t;

	// Scripted opening: the first frame, period and failsafe corner cases.
	script_row_t script [SCRIPT_ROWS] = '{
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_UNUSED,  4'd15, 11'd2047,  CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_LIVE_WR, 4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_ZERO_FRAME},
		'{ROW_REQ, CMD_TICK,    4'd9,  11'd1,     CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_FS_WR,   4'd15, 11'd2047,  CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_FS_WR,   4'd0,  11'h2AA,   CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_LIVE_WR, 4'd15, 11'd2047,  CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_MODEL},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_FAILSAFE_DELAY, 16'd1,     CHK_MODEL},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_CUSTOM_FS,      16'd1,     CHK_MODEL},
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_MODEL},
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_MODEL},
		'{ROW_REQ, CMD_LIVE_WR, 4'd7,  11'h555,   CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_MODEL},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_OUTPUT_ENABLE,  16'hFFFE,  CHK_MODEL},
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_LIVE_WR, 4'd3,  11'h400,   CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_OUTPUT_ENABLE,  16'd1,     CHK_MODEL},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'h00FF,  CHK_MODEL},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_FAILSAFE_DELAY, 16'hFFFF,  CHK_MODEL},
		'{ROW_REG, CMD_TICK,    4'd0,  11'd0,     CFG_CUSTOM_FS,      16'd0,     CHK_MODEL},
		'{ROW_REQ, CMD_TICK,    4'd0,  11'd0,     CFG_FRAME_PERIOD,   16'd0,     CHK_QUIET}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = CMD_TICK;
	logic [CH_IDX_W-1:0] channel_index = '0;
	logic [CH_W-1:0] channel_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WORD_W-1:0] serial_word;
	logic last_in_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_FRAME_PERIOD;
	logic [15:0] cfg_data = '0;

	// Predictor state: stores, counters and register copies.
	logic [CH_W-1:0] live_store [NUM_CH] = '{default: '0};
	logic [CH_W-1:0] fs_store [NUM_CH] = '{default: '0};
	logic live_seen = 1'b0;
	logic [15:0] quiet_ms = '0;
	logic [7:0] frame_age_ms = 8'hFF;
	logic [7:0] cfg_period = FRAME_PERIOD_RST;
	logic [15:0] cfg_fs_delay = FAILSAFE_DELAY_RST;
	logic cfg_out_en = 1'b1;
	logic cfg_copy_fs = 1'b0;
	logic [7:0] frame_bytes [FRAME_BYTES];

	frame_word_t expected_words [$];

	int unsigned burst_left = 0;
	int unsigned requests_done = 0;
	int unsigned reg_writes = 0;
	int unsigned flagged_frames = 0;
	int unsigned words_seen = 0;
	int unsigned frames_seen = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;

	sbus_frame_generator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.serial_word   (serial_word),
		.last_in_frame (last_in_frame),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int unsigned expv, int unsigned gotv);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, expv, gotv);
	endtask

	// Advances the predictor by one request and fills frame_bytes when a
	// tick sends a frame.
	task automatic apply_request(input logic [1:0] cmd, input logic [CH_IDX_W-1:0] idx,
		input logic [CH_W-1:0] val, output bit emitted, output bit flagged);
		emitted = 1'b0;
		flagged = 1'b0;
		case (cmd)
			CMD_LIVE_WR: begin
				live_store[idx] = val;
				live_seen = 1'b1;
				quiet_ms = '0;
			end
			CMD_FS_WR: begin
				fs_store[idx] = val;
			end
			CMD_TICK: begin
				if (quiet_ms != 16'hFFFF)
					quiet_ms++;
				if (frame_age_ms != 8'hFF)
					frame_age_ms++;
				if (live_seen && cfg_out_en && frame_age_ms >= cfg_period) begin
					emitted = 1'b1;
					frame_age_ms = '0;
					// Long silence raises the flag and may restore the failsafe values.
					if (quiet_ms > cfg_fs_delay) begin
						flagged = 1'b1;
						if (cfg_copy_fs)
							live_store = fs_store;
					end
					frame_bytes[0] = SYNC_BYTE;
					// Channels are packed LSB first, eleven bits each.
					for (int b = 0; b < (DATA_LAST - DATA_FIRST + 1) * 8; b++)
						frame_bytes[DATA_FIRST + b / 8][b % 8] = live_store[b / CH_W][b % CH_W];
					frame_bytes[FLAG_POS] = flagged ? FAILSAFE_FLAG : NO_FLAG;
					frame_bytes[FRAME_BYTES - 1] = END_BYTE;
				end
			end
			default: begin
				// The unused command leaves everything as it was.
			end
		endcase
	endtask

	// Offers one request in the current burst, then records what it should send.
	task automatic issue_request(input logic [1:0] cmd, input logic [CH_IDX_W-1:0] idx,
		input logic [CH_W-1:0] val, input chk_t chk);
		int unsigned gap;
		bit emitted;
		bit flagged;
		frame_word_t w;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		channel_index <= idx;
		channel_value <= val;
		do @(posedge clk); while (!in_ready);
		requests_done++;
		apply_request(cmd, idx, val, emitted, flagged);
		// Scripted rows may carry an expectation typed in by hand.
		if (chk == CHK_QUIET) begin
			emitted = 1'b0;
		end else if (chk == CHK_ZERO_FRAME) begin
			emitted = 1'b1;
			flagged = 1'b0;
			frame_bytes[0] = SYNC_BYTE;
			for (int i = 1; i < FRAME_BYTES; i++)
				frame_bytes[i] = '0;
		end
		if (emitted) begin
			if (flagged)
				flagged_frames++;
			for (int i = 0; i < FRAME_BYTES; i++) begin
				w.word = {STOP_BIT, ^frame_bytes[i], frame_bytes[i]};
				w.last = (i == FRAME_BYTES - 1);
				expected_words.push_back(w);
			end
		end
	endtask

	// Register writes happen only once the core has sent everything it owes.
	task automatic write_register(input cfg_reg_t r, input logic [15:0] d);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (r)
			CFG_FRAME_PERIOD:   cfg_period = d[7:0];
			CFG_FAILSAFE_DELAY: cfg_fs_delay = d;
			CFG_OUTPUT_ENABLE:  cfg_out_en = d[0];
			CFG_CUSTOM_FS:      cfg_copy_fs = d[0];
			default: ;
		endcase
	endtask

	// Output side: random ready patterns, plus one long hold-off mid-run.
	initial begin : rx_side
		rx_mode_t mode;
		int unsigned mode_left;
		bit held;
		mode = RX_OPEN;
		mode_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && words_seen >= 150 && out_valid && in_valid) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 64);
			end
			mode_left--;
			case (mode)
				RX_OPEN:  out_ready <= 1'b1;
				RX_HALF:  out_ready <= 1'($urandom_range(0, 1));
				default:  out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare each accepted serial word with the oldest expectation.
	always @(posedge clk) begin : word_check
		frame_word_t want;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (last_in_frame)
				frames_seen++;
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected serial word", 0, serial_word);
			end else begin
				want = expected_words.pop_front();
				if (serial_word !== want.word)
					report_mismatch("serial_word", want.word, serial_word);
				if (last_in_frame !== want.last)
					report_mismatch("last_in_frame", want.last, last_in_frame);
			end
		end
	end

	// Abort when no channel has moved anything for too long.
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus: scripted rows, then randomized phases with fresh register values.
	initial begin : stimulus
		int unsigned sent;
		int unsigned tick_pct;
		int unsigned roll;
		logic [1:0] cmd;
		logic [7:0] per;
		logic [15:0] dly;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (script[n]) begin
			if (script[n].kind == ROW_REG)
				write_register(script[n].reg_sel, script[n].data);
			else
				issue_request(script[n].cmd, script[n].idx, script[n].val, script[n].chk);
		end

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case ($urandom_range(0, 5))
				0:       per = 8'd0;
				1:       per = 8'd1;
				2:       per = 8'hFF;
				default: per = 8'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 4))
				0:       dly = 16'd1;
				1:       dly = 16'hFFFF;
				2:       dly = 16'($urandom_range(7, 40));
				default: dly = 16'($urandom_range(1, 6));
			endcase
			write_register(CFG_FRAME_PERIOD, {8'($urandom_range(0, 255)), per});
			write_register(CFG_FAILSAFE_DELAY, dly);
			write_register(CFG_OUTPUT_ENABLE,
				{15'($urandom_range(0, 32767)), 1'($urandom_range(0, 4) != 0)});
			write_register(CFG_CUSTOM_FS,
				{15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))});

			// Ticks dominate some phases so that silence builds up.
			tick_pct = $urandom_range(30, 75);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < tick_pct) begin
					cmd = CMD_TICK;
				end else begin
					case ($urandom_range(0, 9))
						0:       cmd = CMD_UNUSED;
						1, 2, 3: cmd = CMD_FS_WR;
						default: cmd = CMD_LIVE_WR;
					endcase
				end
				issue_request(cmd, CH_IDX_W'($urandom_range(0, NUM_CH - 1)),
					CH_W'($urandom_range(0, 2047)), CHK_MODEL);
				if (cmd != CMD_UNUSED)
					sent++;
			end
		end

		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d register writes over %0d random phases.",
			requests_done, reg_writes, RAND_PHASES);
		$display("Checked %0d serial words in %0d frames, %0d of them with the failsafe flag.",
			words_seen, frames_seen, flagged_frames);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sbus_frame_generator_core.f
src/sfg_pkg.sv
src/sfg_chan_store.sv
src/sfg_frame_seq.sv
src/sbus_frame_generator_core.sv
sim/tb_top.sv
